// ===== design/softmax_backward_row_assert.svh =====
// softmax_backward_row_assert.svh: assertion macros for the softmax backward row block
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef SOFTMAX_BACKWARD_ROW_ASSERT_SVH
`define SOFTMAX_BACKWARD_ROW_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define SBR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sbr assertion failed");
// next-cycle implication
`define SBR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sbr assertion failed");
`else
`define SBR_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define SBR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== design/sbr_pkg.sv =====
// sbr_pkg: widths, register codes, control structs and helper functions
// for the softmax backward row block; no dependencies
`default_nettype none

package sbr_pkg;

   localparam int DATA_W             = 16;
   localparam int Q_FRAC             = 12;
   localparam int E_FRAC             = 16;
   localparam int FRAC_W             = 15;
   localparam int EXP_W              = 17;
   localparam int SUM_W              = 40;
   localparam int TERM_W             = 32;
   localparam int LEN_W              = 7;
   localparam int CSR_IDX_W          = 1;
   localparam int CSR_DATA_W         = 7;
   localparam int ROW_LENGTH_RESET   = 64;
   localparam int ROW_MAX_DEF        = 64;
   localparam int EXP_TABLE_SIZE_DEF = 64;
   localparam int DATA_MAX           = 2 ** (DATA_W - 1) - 1;
   localparam int DATA_MIN           = -(2 ** (DATA_W - 1));

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE       = 1'b0,
      CSR_ROW_LENGTH = 1'b1
   } csr_reg_type;

   // issue side of the gradient pipe
   typedef struct packed {
      logic issue_vld;
      logic issue_last;
      logic mode;
   } ctl_type;

   typedef struct packed {
      logic adv;
      logic busy;
   } status_type;

   // restoring long division, only used to build constant tables
   function automatic logic [63:0] const_udiv(input logic [63:0] num, input logic [63:0] dvs);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, dvs}) begin
            rem    = rem - {1'b0, dvs};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // q1.16 sample k of exp(x) on [-8,0]; reciprocal of a truncated q32 taylor sum
   function automatic logic [EXP_W-1:0] exp_sample(input int unsigned k,
                                                   input int unsigned size);
      logic [63:0] den;
      logic [63:0] m;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] q;
      den  = 64'(size - 1);
      m    = den - 64'(k);
      term = 64'd1 << 32;
      sum  = '0;
      for (int n = 1; n <= 100; n++) begin
         if (term != '0) begin
            sum  = sum + term;
            term = const_udiv(term * 64'd8 * m, 64'(n) * den);
         end
      end
      q = const_udiv((64'd1 << 48) + (sum >> 1), sum);
      return EXP_W'(q);
   endfunction

   function automatic logic [DATA_W-1:0] sat_data(input logic signed [63:0] v);
      logic [DATA_W-1:0] r;
      if (v > 64'(DATA_MAX)) begin
         r = DATA_W'(DATA_MAX);
      end else if (v < 64'(DATA_MIN)) begin
         r = DATA_W'(DATA_MIN);
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== design/sbr_store.sv =====
// sbr_store: row store holding {y, dy} pairs, one write and one registered read port
// depends on sbr_pkg
`default_nettype none

module sbr_store #(
   parameter int ROW_MAX = sbr_pkg::ROW_MAX_DEF
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(ROW_MAX)-1:0]    wr_addr,
   input  logic [2*sbr_pkg::DATA_W-1:0]  wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(ROW_MAX)-1:0]    rd_addr,
   output logic [2*sbr_pkg::DATA_W-1:0]  rd_data
);
   import sbr_pkg::*;

   logic [2*DATA_W-1:0] mem_ff [ROW_MAX];
   logic [2*DATA_W-1:0] rd_data_ff;

   // writes happen only while loading; reads are enabled whenever the grad pipe advances,
   // so an entry can be written and read in the same cycle, but read data while loading is unused
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/sbr_exp.sv =====
// sbr_exp: three-stage exp(y) for y in [-8,0], table lookup plus linear interpolation
// depends on sbr_pkg (exp_sample builds the table at elaboration)
`default_nettype none

module sbr_exp #(
   parameter int EXP_TABLE_SIZE = sbr_pkg::EXP_TABLE_SIZE_DEF
) (
   input  logic                                clock,
   input  logic                                adv,
   input  logic signed [sbr_pkg::DATA_W-1:0]   y_value,
   output logic        [sbr_pkg::EXP_W-1:0]    exp_value
);
   import sbr_pkg::*;

   localparam int IDX_W = $clog2(EXP_TABLE_SIZE);
   localparam int SC_W  = FRAC_W + IDX_W;
   localparam int DP_W  = EXP_W + FRAC_W;
   localparam int RND_W = DP_W + 1;

   logic [EXP_W-1:0] lut [EXP_TABLE_SIZE];

   for (genvar k = 0; k < EXP_TABLE_SIZE; k++) begin : g_lut
      assign lut[k] = exp_sample(k, EXP_TABLE_SIZE);
   end

   logic signed [DATA_W-1:0] y_clamp;
   logic [DATA_W-1:0]        t_pos;
   logic [SC_W-1:0]          scaled_ff, scaled_in;
   logic [IDX_W-1:0]         idx;
   logic [FRAC_W-1:0]        frac;
   logic [EXP_W-1:0]         lo_sel, hi_sel;
   logic [EXP_W-1:0]         lo_ff, lo_in;
   logic [DP_W-1:0]          dp_ff, dp_in;
   logic [RND_W-1:0]         rnd;
   logic [EXP_W-1:0]         e_ff, e_in;

   always_comb begin
      // positive inputs clamp to zero, then shift the range to [0, 2^15]
      y_clamp   = y_value[DATA_W-1] ? y_value : '0;
      t_pos     = {~y_clamp[DATA_W-1], y_clamp[DATA_W-2:0]};
      scaled_in = SC_W'(t_pos) * SC_W'(EXP_TABLE_SIZE - 1);

      idx    = scaled_ff[SC_W-1:FRAC_W];
      frac   = scaled_ff[FRAC_W-1:0];
      lo_sel = lut[idx];
      if (idx == IDX_W'(EXP_TABLE_SIZE - 1)) begin
         hi_sel = lo_sel;
      end else begin
         hi_sel = lut[idx + IDX_W'(1)];
      end
      lo_in = lo_sel;
      dp_in = DP_W'(hi_sel - lo_sel) * DP_W'(frac);

      rnd  = RND_W'(dp_ff) + (RND_W'(1) << (FRAC_W - 1));
      e_in = lo_ff + EXP_W'(rnd >> FRAC_W);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         scaled_ff <= scaled_in;
         lo_ff     <= lo_in;
         dp_ff     <= dp_in;
         e_ff      <= e_in;
      end
   end

   assign exp_value = e_ff;

endmodule

`default_nettype wire

// ===== design/sbr_grad.sv =====
// sbr_grad: gradient pipe from store read data to the result register
// depends on sbr_pkg and sbr_exp
`default_nettype none

module sbr_grad #(
   parameter int EXP_TABLE_SIZE = sbr_pkg::EXP_TABLE_SIZE_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sbr_pkg::ctl_type                    ctl,
   output sbr_pkg::status_type                 status,
   input  logic [2*sbr_pkg::DATA_W-1:0]        rd_data,
   input  logic signed [sbr_pkg::SUM_W-1:0]    row_sum,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic signed [sbr_pkg::DATA_W-1:0]   rsp_dx_value,
   output logic                                rsp_last
);
   import sbr_pkg::*;

   localparam int DIFF_W = SUM_W + 1;
   localparam int PROD_W = DATA_W + DIFF_W;
   localparam int SACC_W = PROD_W + 1;
   localparam int EP_W   = EXP_W + 1 + SUM_W;
   localparam int LACC_W = EP_W + 1;
   localparam int DEPTH  = 5;

   logic adv;

   logic [DEPTH-1:0] vld_ff, vld_in;
   logic [DEPTH-1:0] last_ff, last_in;

   logic signed [DATA_W-1:0] s1_y, s1_dy;
   logic signed [DATA_W-1:0] s2_y_ff, s2_dy_ff, s3_dy_ff, s4_dy_ff, s5_dy_ff;
   logic signed [DIFF_W-1:0] s2_diff_ff, s2_diff_in;
   logic signed [PROD_W-1:0] s3_prod_ff, s3_prod_in, s4_prod_ff, s5_prod_ff;
   logic        [EXP_W-1:0]  s4_exp;
   logic signed [EP_W-1:0]   s5_eprod_ff, s5_eprod_in;
   logic signed [SACC_W-1:0] soft_acc, soft_q;
   logic signed [LACC_W-1:0] log_acc, log_q;

   logic                     rsp_valid_ff;
   logic                     rsp_last_ff;
   logic signed [DATA_W-1:0] rsp_dx_ff, rsp_dx_in;

   // the whole pipe holds while the result register is stalled
   assign adv         = !(rsp_valid_ff && rsp_stall);
   assign status.adv  = adv;
   assign status.busy = (|vld_ff) || rsp_valid_ff;

   sbr_exp #(
      .EXP_TABLE_SIZE(EXP_TABLE_SIZE)
   ) u_exp (
      .clock     (clock),
      .adv       (adv),
      .y_value   (s1_y),
      .exp_value (s4_exp)
   );

   always_comb begin
      vld_in  = {vld_ff[DEPTH-2:0], ctl.issue_vld};
      last_in = {last_ff[DEPTH-2:0], ctl.issue_last};

      s1_y  = $signed(rd_data[2*DATA_W-1:DATA_W]);
      s1_dy = $signed(rd_data[DATA_W-1:0]);

      // softmax: y * (dy - sum(y*dy)); q3.12 y times a difference with 24 fraction bits
      s2_diff_in  = (DIFF_W'(s1_dy) <<< Q_FRAC) - DIFF_W'(row_sum);
      s3_prod_in  = PROD_W'(s2_y_ff) * PROD_W'(s2_diff_ff);
      // log-softmax: exp(y) * sum(dy) in q1.16 x q3.12
      s5_eprod_in = EP_W'($signed({1'b0, s4_exp})) * EP_W'(row_sum);

      soft_acc = SACC_W'(s5_prod_ff) + (SACC_W'(1) <<< (2 * Q_FRAC - 1));
      soft_q   = soft_acc >>> (2 * Q_FRAC);
      log_acc  = (LACC_W'(s5_dy_ff) <<< E_FRAC) - LACC_W'(s5_eprod_ff)
               + (LACC_W'(1) <<< (E_FRAC - 1));
      log_q    = log_acc >>> E_FRAC;

      if (ctl.mode) begin
         rsp_dx_in = $signed(sat_data(64'(log_q)));
      end else begin
         rsp_dx_in = $signed(sat_data(64'(soft_q)));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= vld_ff[DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         last_ff     <= last_in;
         s2_y_ff     <= s1_y;
         s2_dy_ff    <= s1_dy;
         s2_diff_ff  <= s2_diff_in;
         s3_dy_ff    <= s2_dy_ff;
         s3_prod_ff  <= s3_prod_in;
         s4_dy_ff    <= s3_dy_ff;
         s4_prod_ff  <= s3_prod_ff;
         s5_dy_ff    <= s4_dy_ff;
         s5_prod_ff  <= s4_prod_ff;
         s5_eprod_ff <= s5_eprod_in;
         rsp_dx_ff   <= rsp_dx_in;
         rsp_last_ff <= last_ff[DEPTH-1];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_dx_value = rsp_dx_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

`default_nettype wire

// ===== design/softmax_backward_row.sv =====
// softmax_backward_row: control fsm, row sum, csr registers; uses sbr_pkg, sbr_store, sbr_grad
// load: one item per cycle into the row store, the sum adds each registered term in the cycle after
// emit: one result per cycle from the store read port unless rsp_stall holds the pipe; after the
//   item that completes the row, results pass the store read register, s2 to s5 and the result
//   register, and input reopens once the last result has left the pipe
// reset clears control, row sum, mode (softmax) and row_length (64); the store is not cleared
`default_nettype none
`include "softmax_backward_row_assert.svh"

module softmax_backward_row #(
   parameter int ROW_MAX        = sbr_pkg::ROW_MAX_DEF,
   parameter int EXP_TABLE_SIZE = sbr_pkg::EXP_TABLE_SIZE_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [sbr_pkg::DATA_W-1:0]    req_y_value,
   input  logic signed [sbr_pkg::DATA_W-1:0]    req_dy_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [sbr_pkg::DATA_W-1:0]    rsp_dx_value,
   output logic                                 rsp_last,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sbr_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [sbr_pkg::CSR_DATA_W-1:0]       csr_data
);
   import sbr_pkg::*;

   localparam int ADDR_W = $clog2(ROW_MAX);

   typedef enum logic [2:0] {
      S_LOAD  = 3'b001,
      S_ISSUE = 3'b010,
      S_DRAIN = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [ADDR_W-1:0]        load_count_ff, load_count_in;
   logic [ADDR_W-1:0]        last_addr_ff, last_addr_in;
   logic [ADDR_W-1:0]        rd_addr_ff, rd_addr_in;
   logic                     mode_ff, mode_in;
   logic [LEN_W-1:0]         row_length_ff, row_length_in;
   logic signed [SUM_W-1:0]  row_sum_ff, row_sum_in;
   logic signed [TERM_W-1:0] term_ff, term_in;
   logic                     term_vld_ff;

   logic             req_accept;
   logic [LEN_W-1:0] len_eff;
   logic [LEN_W-1:0] load_next;
   logic             row_done;
   logic             issue_last;
   logic             sum_clear;

   ctl_type    ctl;
   status_type status;

   assign req_stall  = (state_ff != S_LOAD);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   always_comb begin
      if (row_length_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (row_length_ff > LEN_W'(ROW_MAX)) begin
         len_eff = LEN_W'(ROW_MAX);
      end else begin
         len_eff = row_length_ff;
      end
      load_next  = LEN_W'(load_count_ff) + LEN_W'(1);
      row_done   = (load_next >= len_eff);
      issue_last = (rd_addr_ff == last_addr_ff);

      if (mode_ff) begin
         term_in = TERM_W'(req_dy_value);
      end else begin
         term_in = TERM_W'(req_y_value) * TERM_W'(req_dy_value);
      end
   end

   always_comb begin
      ctl.issue_vld  = (state_ff == S_ISSUE);
      ctl.issue_last = issue_last;
      ctl.mode       = mode_ff;
   end

   always_comb begin
      state_in      = state_ff;
      load_count_in = load_count_ff;
      last_addr_in  = last_addr_ff;
      rd_addr_in    = rd_addr_ff;
      sum_clear     = 1'b0;
      case (state_ff)
         S_LOAD: begin
            if (req_accept) begin
               if (row_done) begin
                  state_in      = S_ISSUE;
                  load_count_in = '0;
                  last_addr_in  = load_count_ff;
                  rd_addr_in    = '0;
               end else begin
                  load_count_in = load_count_ff + ADDR_W'(1);
               end
            end
         end
         S_ISSUE: begin
            if (status.adv) begin
               if (issue_last) begin
                  state_in = S_DRAIN;
               end else begin
                  rd_addr_in = rd_addr_ff + ADDR_W'(1);
               end
            end
         end
         S_DRAIN: begin
            // the sum stays put until the last result has left the pipe
            if (!status.busy) begin
               state_in  = S_LOAD;
               sum_clear = 1'b1;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_comb begin
      if (sum_clear) begin
         row_sum_in = '0;
      end else if (term_vld_ff) begin
         row_sum_in = row_sum_ff + SUM_W'(term_ff);
      end else begin
         row_sum_in = row_sum_ff;
      end
   end

   always_comb begin
      mode_in       = mode_ff;
      row_length_in = row_length_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MODE: begin
               mode_in = csr_data[0];
            end
            CSR_ROW_LENGTH: begin
               row_length_in = LEN_W'(csr_data);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_LOAD;
         load_count_ff <= '0;
         last_addr_ff  <= '0;
         rd_addr_ff    <= '0;
         mode_ff       <= 1'b0;
         row_length_ff <= LEN_W'(ROW_LENGTH_RESET);
         row_sum_ff    <= '0;
         term_vld_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         load_count_ff <= load_count_in;
         last_addr_ff  <= last_addr_in;
         rd_addr_ff    <= rd_addr_in;
         mode_ff       <= mode_in;
         row_length_ff <= row_length_in;
         row_sum_ff    <= row_sum_in;
         term_vld_ff   <= req_accept;
      end
   end

   // product (dy in log-softmax mode) registered before it reaches the 40-bit accumulator
   always_ff @(posedge clock) begin
      if (req_accept) begin
         term_ff <= term_in;
      end
   end

   logic [2*DATA_W-1:0] rd_data;

   sbr_store #(
      .ROW_MAX(ROW_MAX)
   ) u_store (
      .clock   (clock),
      .wr_en   (req_accept),
      .wr_addr (load_count_ff),
      .wr_data ({req_y_value, req_dy_value}),
      .rd_en   (status.adv),
      .rd_addr (rd_addr_ff),
      .rd_data (rd_data)
   );

   sbr_grad #(
      .EXP_TABLE_SIZE(EXP_TABLE_SIZE)
   ) u_grad (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .status       (status),
      .rd_data      (rd_data),
      .row_sum      (row_sum_ff),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_dx_value (rsp_dx_value),
      .rsp_last     (rsp_last)
   );

   `SBR_ASSERT_IMPLY(a_no_rsp_while_loading, clock, reset, rsp_valid, state_ff != S_LOAD)
   `SBR_ASSERT_NEXT(a_last_ends_row, clock, reset, rsp_valid && !rsp_stall && rsp_last, !rsp_valid)
   `SBR_ASSERT_IMPLY(a_count_cleared_on_emit, clock, reset, state_ff != S_LOAD, load_count_ff == '0)

endmodule

`default_nettype wire

// ===== tb/sv/tb_softmax_backward_row.sv =====
// tb_softmax_backward_row: self-checking bench for the softmax / log-softmax backward row block
// drives rows of (y, dy) items, predicts dx in-house or from the plan, scoreboards in order
// depends on sbr_pkg and softmax_backward_row
`default_nettype none

module tb_softmax_backward_row;
   import sbr_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int SETTLE_CYC   = 12;
   localparam int RANDOM_ITEMS = 430;
   localparam int PLAN_ROWS    = 31;

   typedef enum logic {
      GRAD_SOFTMAX     = 1'b0,
      GRAD_LOG_SOFTMAX = 1'b1
   } grad_mode_type;

   typedef enum logic {
      PLAN_ITEM = 1'b0,
      PLAN_CFG  = 1'b1
   } plan_kind_type;

   typedef struct {
      plan_kind_type            kind;
      grad_mode_type            mode;
      logic [LEN_W-1:0]         len;
      logic signed [DATA_W-1:0] y;
      logic signed [DATA_W-1:0] dy;
      logic                     typed;
      logic signed [DATA_W-1:0] dx;
   } plan_row_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] dx_value;
      logic                     last;
   } grad_type;

   logic                     clock        = 1'b0;
   logic                     reset        = 1'b1;
   logic                     req_valid    = 1'b0;
   logic                     req_stall;
   logic signed [DATA_W-1:0] req_y_value  = '0;
   logic signed [DATA_W-1:0] req_dy_value = '0;
   logic                     rsp_valid;
   logic                     rsp_stall    = 1'b0;
   logic signed [DATA_W-1:0] rsp_dx_value;
   logic                     rsp_last;
   logic                     csr_valid    = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index    = '0;
   logic [CSR_DATA_W-1:0]    csr_data     = '0;

   softmax_backward_row dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_y_value  (req_y_value),
      .req_dy_value (req_dy_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_dx_value (rsp_dx_value),
      .rsp_last     (rsp_last),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   grad_mode_type            cur_mode = GRAD_SOFTMAX;
   logic [LEN_W-1:0]         cur_len  = LEN_W'(ROW_LENGTH_RESET);
   logic signed [DATA_W-1:0] y_row  [ROW_MAX_DEF];
   logic signed [DATA_W-1:0] dy_row [ROW_MAX_DEF];
   longint                   grad_sum = 0;
   int unsigned              loaded   = 0;
   longint unsigned          exp_tbl [EXP_TABLE_SIZE_DEF];

   grad_type      grad_expect [$];
   grad_type      want;
   int            errors      = 0;
   int            items_sent  = 0;
   int            grads_seen  = 0;
   int            cfg_writes  = 0;
   int            longest_row = 0;
   int            stuck       = 0;
   logic          calm        = 1'b0;
   plan_row_type  plan [PLAN_ROWS];

   // q1.16 exp sample k, exp(-x) as the reciprocal of the truncated q32 series of exp(x)
   function automatic longint unsigned exp_point(int unsigned k);
      longint unsigned span, m, term, total, n;
      span  = EXP_TABLE_SIZE_DEF - 1;
      m     = span - k;
      term  = 64'd1 << 32;
      total = 0;
      for (n = 1; n <= 100 && term != 0; n++) begin
         total = total + term;
         term  = term * 64'd8 * m / (n * span);
      end
      return ((64'd1 << 48) + total / 2) / total;
   endfunction

   function automatic longint unsigned exp_lookup(logic signed [DATA_W-1:0] y);
      longint unsigned t, scaled, idx, frac, lo, hi;
      t      = (y > 0) ? 64'd32768 : longint'(unsigned'(longint'(y) + 32768));
      scaled = t * (EXP_TABLE_SIZE_DEF - 1);
      idx    = scaled >> FRAC_W;
      frac   = scaled & 64'h7fff;
      if (idx >= EXP_TABLE_SIZE_DEF - 1)
         return exp_tbl[EXP_TABLE_SIZE_DEF-1];
      lo = exp_tbl[idx];
      hi = exp_tbl[idx+1];
      return lo + (((hi - lo) * frac + 64'd16384) >> FRAC_W);
   endfunction

   function automatic logic signed [DATA_W-1:0] clip16(longint v);
      if (v > DATA_MAX) return DATA_W'(DATA_MAX);
      if (v < DATA_MIN) return DATA_W'(DATA_MIN);
      return DATA_W'(v);
   endfunction

   function automatic int unsigned row_span(logic [LEN_W-1:0] len);
      if (len == 0) return 1;
      if (len > ROW_MAX_DEF) return ROW_MAX_DEF;
      return len;
   endfunction

   // loads one item into the row copy; on the closing item queues the whole row of gradients
   task automatic predict_grads(input logic signed [DATA_W-1:0] y,
                                input logic signed [DATA_W-1:0] dy,
                                input logic typed,
                                input logic signed [DATA_W-1:0] typed_dx);
      int unsigned span, slot, count, i;
      longint      yi, di, acc, e;
      grad_type    g;
      span = row_span(cur_len);
      slot = (loaded >= ROW_MAX_DEF) ? ROW_MAX_DEF - 1 : loaded;
      y_row[slot]  = y;
      dy_row[slot] = dy;
      if (cur_mode == GRAD_LOG_SOFTMAX)
         grad_sum = grad_sum + longint'(dy);
      else
         grad_sum = grad_sum + longint'(y) * longint'(dy);
      count = slot + 1;
      if (count < span) begin
         loaded = count;
         return;
      end
      for (i = 0; i < count; i++) begin
         yi = longint'(y_row[i]);
         di = longint'(dy_row[i]);
         if (cur_mode == GRAD_LOG_SOFTMAX) begin
            e   = longint'(exp_lookup(y_row[i]));
            acc = (di * 65536 - e * grad_sum + 32768) >>> E_FRAC;
         end else begin
            acc = (yi * (di * 4096 - grad_sum) + (longint'(1) << 23)) >>> 24;
         end
         g.dx_value = typed ? typed_dx : clip16(acc);
         g.last     = (i + 1 == count);
         grad_expect = {grad_expect, g};
      end
      if (count > longest_row) longest_row = count;
      grad_sum = 0;
      loaded   = 0;
   endtask

   task automatic send_item(input logic signed [DATA_W-1:0] y,
                            input logic signed [DATA_W-1:0] dy,
                            input logic typed,
                            input logic signed [DATA_W-1:0] typed_dx);
      while (!calm && $urandom_range(0, 99) < 22) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_y_value  <= y;
      req_dy_value <= dy;
      forever begin
         @(negedge clock);
         if (!req_stall) break;
      end
      @(posedge clock);
      items_sent++;
      predict_grads(y, dy, typed, typed_dx);
   endtask

   // input held off until every queued gradient is out and the sum pipe has drained
   task automatic drain_rows();
      req_valid <= 1'b0;
      while (grad_expect.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_reg(input csr_reg_type idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      forever begin
         @(negedge clock);
         if (csr_ready) break;
      end
      @(posedge clock);
      cfg_writes++;
   endtask

   task automatic set_config(input grad_mode_type m, input logic [LEN_W-1:0] len);
      drain_rows();
      write_reg(CSR_MODE, CSR_DATA_W'(m));
      write_reg(CSR_ROW_LENGTH, len);
      csr_valid <= 1'b0;
      cur_mode = m;
      cur_len  = len;
   endtask

   function automatic logic signed [DATA_W-1:0] edge_value();
      case ($urandom_range(0, 4))
         0:       return 16'sh8000;
         1:       return 16'sh7fff;
         2:       return 16'sh0000;
         3:       return 16'shffff;
         default: return 16'sh0001;
      endcase
   endfunction

   function automatic logic signed [DATA_W-1:0] rand_y(grad_mode_type m);
      case ($urandom_range(0, 9))
         0:       return edge_value();
         1, 2:    return DATA_W'($urandom);
         default: begin
            // probabilities for softmax, log-probabilities for log-softmax
            if (m == GRAD_LOG_SOFTMAX) return DATA_W'(-int'($urandom_range(0, 32768)));
            return DATA_W'($urandom_range(0, 4096));
         end
      endcase
   endfunction

   function automatic logic signed [DATA_W-1:0] rand_dy();
      case ($urandom_range(0, 9))
         0:       return edge_value();
         1, 2:    return DATA_W'($urandom);
         default: return DATA_W'(int'($urandom_range(0, 4096)) - 2048);
      endcase
   endfunction

   function automatic logic [LEN_W-1:0] rand_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 4)  return LEN_W'(ROW_MAX_DEF);
      if (r < 8)  return ($urandom_range(0, 1) != 0) ? 7'd127 : LEN_W'($urandom_range(65, 126));
      if (r < 14) return '0;
      if (r < 30) return LEN_W'($urandom_range(9, 63));
      return LEN_W'($urandom_range(1, 8));
   endfunction

   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(0, 99) < 22);
   end

   // result side: an item is taken at the next rising edge, so compare here
   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         grads_seen++;
         if (grad_expect.size() == 0) begin
            $error("dx_value: no result expected, got %0d (last %0b)", rsp_dx_value, rsp_last);
            errors++;
         end else begin
            want = grad_expect.pop_front();
            if (rsp_dx_value !== want.dx_value) begin
               $error("dx_value: expected %0d, got %0d", want.dx_value, rsp_dx_value);
               errors++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_last);
               errors++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         stuck = 0;
      else
         stuck++;
      if (stuck == STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      int unsigned       k, n, span, rand_done;
      grad_mode_type     m;
      logic [LEN_W-1:0]  len;

      for (k = 0; k < EXP_TABLE_SIZE_DEF; k++) exp_tbl[k] = exp_point(k);

      plan = '{
         // softmax, one-item rows
         '{PLAN_CFG,  GRAD_SOFTMAX,     7'd1, 16'sd0,    16'sd0,    1'b0, 16'sd0},
         '{PLAN_ITEM, GRAD_SOFTMAX,     7'd0, 16'sd0,    16'sd0,    1'b1, 16'sd0},
         '{PLAN_ITEM, GRAD_SOFTMAX,     7'd0, 16'sh8000, 16'sh8000, 1'b1, 16'sh7fff},
         '{PLAN_ITEM, GRAD_SOFTMAX,     7'd0, 16'sh7fff, 16'sh8000, 1'b1, 16'sh7fff},
         '{PLAN_ITEM, GRAD_SOFTMAX,     7'd0, 16'sh7fff, 16'sh7fff, 1'b1, 16'sh8000},
         '{PLAN_ITEM, GRAD_SOFTMAX,     7'd0, 16'sd4096, 16'sd4096, 1'b1, 16'sd0},
         '{PLAN_ITEM, GRAD_SOFTMAX,     7'd0, 16'sd4096, -16'sd2048, 1'b0, 16'sd0},
         // log-softmax, one-item rows; y above zero clamps
         '{PLAN_CFG,  GRAD_LOG_SOFTMAX, 7'd1, 16'sd0,    16'sd0,    1'b0, 16'sd0},
         '{PLAN_ITEM, GRAD_SOFTMAX,     7'd0, 16'sd0,    16'sh7fff, 1'b1, 16'sd0},
         '{PLAN_ITEM, GRAD_SOFTMAX,     7'd0, 16'sh7fff, 16'sh8000, 1'b1, 16'sd0},
         '{PLAN_ITEM, GRAD_SOFTMAX,     7'd0, 16'sh8000, 16'sh7fff, 1'b0, 16'sd0},
         '{PLAN_ITEM, GRAD_SOFTMAX,     7'd0, 16'sh8000, 16'sh8000, 1'b0, 16'sd0},
         '{PLAN_ITEM, GRAD_SOFTMAX,     7'd0, -16'sd1,   16'sd1,    1'b0, 16'sd0},
         // zero length behaves as one
         '{PLAN_CFG,  GRAD_LOG_SOFTMAX, 7'd0, 16'sd0,    16'sd0,    1'b0, 16'sd0},
         '{PLAN_ITEM, GRAD_SOFTMAX,     7'd0, -16'sd100, 16'sd5000, 1'b0, 16'sd0},
         // length lowered mid-row: next item closes a row of three
         '{PLAN_CFG,  GRAD_SOFTMAX,     7'd4, 16'sd0,    16'sd0,    1'b0, 16'sd0},
         '{PLAN_ITEM, GRAD_SOFTMAX,     7'd0, 16'sd2000, 16'sd300,  1'b0, 16'sd0},
         '{PLAN_ITEM, GRAD_SOFTMAX,     7'd0, 16'sd1000, -16'sd700, 1'b0, 16'sd0},
         '{PLAN_CFG,  GRAD_SOFTMAX,     7'd2, 16'sd0,    16'sd0,    1'b0, 16'sd0},
         '{PLAN_ITEM, GRAD_SOFTMAX,     7'd0, 16'sd1096, 16'sd1200, 1'b0, 16'sd0},
         // mode switched mid-row
         '{PLAN_CFG,  GRAD_LOG_SOFTMAX, 7'd3, 16'sd0,    16'sd0,    1'b0, 16'sd0},
         '{PLAN_ITEM, GRAD_SOFTMAX,     7'd0, -16'sd4096, 16'sd1000, 1'b0, 16'sd0},
         '{PLAN_CFG,  GRAD_SOFTMAX,     7'd3, 16'sd0,    16'sd0,    1'b0, 16'sd0},
         '{PLAN_ITEM, GRAD_SOFTMAX,     7'd0, 16'sd800,  16'sd3000, 1'b0, 16'sd0},
         '{PLAN_ITEM, GRAD_SOFTMAX,     7'd0, -16'sd2000, 16'sd700, 1'b0, 16'sd0},
         // plain log-softmax row
         '{PLAN_CFG,  GRAD_LOG_SOFTMAX, 7'd5, 16'sd0,    16'sd0,    1'b0, 16'sd0},
         '{PLAN_ITEM, GRAD_SOFTMAX,     7'd0, -16'sd3000, 16'sd400, 1'b0, 16'sd0},
         '{PLAN_ITEM, GRAD_SOFTMAX,     7'd0, -16'sd9000, -16'sd1500, 1'b0, 16'sd0},
         '{PLAN_ITEM, GRAD_SOFTMAX,     7'd0, -16'sd200, 16'sd2500, 1'b0, 16'sd0},
         '{PLAN_ITEM, GRAD_SOFTMAX,     7'd0, -16'sd20000, 16'sh7fff, 1'b0, 16'sd0},
         '{PLAN_ITEM, GRAD_SOFTMAX,     7'd0, 16'sd0,    16'sh8000, 1'b0, 16'sd0}
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (k = 0; k < PLAN_ROWS; k++) begin
         if (plan[k].kind == PLAN_CFG)
            set_config(plan[k].mode, plan[k].len);
         else
            send_item(plan[k].y, plan[k].dy, plan[k].typed, plan[k].dx);
      end

      // random rows; a partial row left at a phase end meets the next setting mid-row
      rand_done = 0;
      while (rand_done < RANDOM_ITEMS) begin
         calm = (rand_done >= 150 && rand_done < 260);
         m    = grad_mode_type'($urandom_range(0, 1));
         len  = rand_len();
         set_config(m, len);
         span = row_span(len);
         n    = ((span > 8) ? 1 : $urandom_range(1, 3)) * span;
         if ($urandom_range(0, 3) == 0) n = n + $urandom_range(0, span - 1);
         repeat (n) send_item(rand_y(m), rand_dy(), 1'b0, '0);
         rand_done = rand_done + n;
      end
      calm = 1'b0;

      drain_rows();
      repeat (20) @(posedge clock);
      $display("covered %0d items in both modes, %0d gradients checked, %0d register writes",
               items_sent, grads_seen, cfg_writes);
      $display("longest row %0d, zero and oversize lengths, mid-row length and mode changes",
               longest_row);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire
